### rtl/core/cnms_pkg.sv
// ----------------------------------------------------------------------------
// Canny non-maximum suppression package
// Shared constants, the direction sector type and default parameter values.
// ----------------------------------------------------------------------------
package cnms_pkg;

  localparam int IMAGE_SIZE_DEF = 256;
  localparam int MAG_BITS_DEF   = 16;
  localparam int GRAD_BITS_DEF  = 16;

  // Border width register.
  localparam int             BW_W     = 6;
  localparam logic [BW_W-1:0] BW_RESET = 6'd3;

  // Row and column indices on the result port.
  localparam int IDX_OUT_W = 8;

  // Tangent limits 0.4142 and 2.4142 as fractions over a common denominator.
  localparam int TAN_DEN      = 10000;
  localparam int TAN_LOW_NUM  = 4142;
  localparam int TAN_HIGH_NUM = 24142;

  // Width of the cross products: signed gradient plus one bit, 15-bit factor.
  localparam int TAN_FACTOR_W = 15;

  typedef enum logic [1:0] {
    SEC_HORIZ   = 2'd0,
    SEC_RISING  = 2'd1,
    SEC_FALLING = 2'd2,
    SEC_VERT    = 2'd3
  } sector_t;

endpackage

### rtl/core/cnms_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with enable and registered read-first data.
// ----------------------------------------------------------------------------
module cnms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/cnms_sector.sv
// ----------------------------------------------------------------------------
// Gradient direction sector
// Places gy/gx in one of four sectors by exact integer cross-multiplication.
// ----------------------------------------------------------------------------
module cnms_sector #(
  parameter int GRAD_BITS = 16
) (
  input  logic signed [GRAD_BITS-1:0] grad_x,
  input  logic signed [GRAD_BITS-1:0] grad_y,
  output cnms_pkg::sector_t           sector
);

  import cnms_pkg::*;

  localparam int GN_W   = GRAD_BITS + 1;
  localparam int PROD_W = GN_W + TAN_FACTOR_W;

  localparam logic signed [PROD_W-1:0] K_DEN  = PROD_W'(TAN_DEN);
  localparam logic signed [PROD_W-1:0] K_LOW  = PROD_W'(TAN_LOW_NUM);
  localparam logic signed [PROD_W-1:0] K_HIGH = PROD_W'(TAN_HIGH_NUM);

  logic signed [GN_W-1:0]   gx_n;
  logic signed [GN_W-1:0]   gy_n;
  logic signed [PROD_W-1:0] prod_g;
  logic signed [PROD_W-1:0] prod_a;
  logic signed [PROD_W-1:0] prod_b;

  // Fold the left half-plane onto the right so that gx is positive.
  always_comb begin
    if (grad_x[GRAD_BITS-1]) begin
      gx_n = -GN_W'(grad_x);
      gy_n = -GN_W'(grad_y);
    end else begin
      gx_n = GN_W'(grad_x);
      gy_n = GN_W'(grad_y);
    end
  end

  assign prod_g = PROD_W'(gy_n) * K_DEN;
  assign prod_a = PROD_W'(gx_n) * K_LOW;
  assign prod_b = PROD_W'(gx_n) * K_HIGH;

  always_comb begin
    if (grad_x == '0) begin
      // A zero x gradient behaves as a tiny positive value.
      sector = (grad_y == '0) ? SEC_HORIZ : SEC_VERT;
    end else if (prod_g <= prod_a && prod_g > -prod_a) begin
      sector = SEC_HORIZ;
    end else if (prod_g <= prod_b && prod_g > prod_a) begin
      sector = SEC_RISING;
    end else if (prod_g <= -prod_a && prod_g > -prod_b) begin
      sector = SEC_FALLING;
    end else begin
      sector = SEC_VERT;
    end
  end

endmodule

### rtl/core/canny_non_max_suppression_unit.sv
// ----------------------------------------------------------------------------
// Canny non-maximum suppression unit
// Thins a raster gradient stream to single-pixel edge candidates.
// ----------------------------------------------------------------------------
// Usage. Pixels arrive in raster order on the in_ channel, one word per pixel
// with its x and y gradients, its magnitude and a start-of-frame mark that
// puts the pixel at row 0, column 0. A result word leaves on the out_ channel
// for every input pixel that is not in the first row or first column; it
// describes the centre pixel one row up and one column to the left, with its
// direction sector, its magnitude and an edge flag that is set only if the
// magnitude strictly exceeds both neighbours along that direction and the
// pixel lies outside the border. The user must write the border width via
// cfg_ only while the unit is idle (not enforced); cfg_ready is always high.
// Timing. An accepted word is captured in the stage register; its result is
// loaded into the output register as the word moves on, held off by a full,
// stalled output register. While in_stall is low a new pixel is taken in
// every cycle: one line-store read at acceptance and one write per pixel.
// in_stall rises only while a result waits in the output register under
// out_stall and the word in the stage register has a result of its own.
// Reset clears the counters, the valid flags, the centre sector and sets the
// border width to three. The line stores are not cleared: only border
// centres ever see unwritten entries.
// ----------------------------------------------------------------------------
module canny_non_max_suppression_unit #(
  parameter int IMAGE_SIZE = cnms_pkg::IMAGE_SIZE_DEF,
  parameter int MAG_BITS   = cnms_pkg::MAG_BITS_DEF,
  parameter int GRAD_BITS  = cnms_pkg::GRAD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Pixel input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [GRAD_BITS-1:0]      in_grad_x,
  input  logic signed [GRAD_BITS-1:0]      in_grad_y,
  input  logic [MAG_BITS-1:0]              in_magnitude,
  input  logic                             in_start_of_frame,
  // Result output
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_edge_flag,
  output logic [1:0]                       out_sector,
  output logic [MAG_BITS-1:0]              out_center_magnitude,
  output logic [cnms_pkg::IDX_OUT_W-1:0]   out_row_index,
  output logic [cnms_pkg::IDX_OUT_W-1:0]   out_column_index,
  // Border width register
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cnms_pkg::BW_W-1:0]        cfg_data
);

  import cnms_pkg::*;

  localparam int IDX_W   = $clog2(IMAGE_SIZE);
  localparam int SEC_W   = $bits(sector_t);
  // Line store entry: middle line magnitude, upper line magnitude, sector.
  localparam int LINE_W  = 2 * MAG_BITS + SEC_W;
  localparam int SUM_W   = ((IDX_W > BW_W) ? IDX_W : BW_W) + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(IMAGE_SIZE - 1);
  localparam logic [SUM_W-1:0] SIZE_SUM = SUM_W'(IMAGE_SIZE);

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  logic [BW_W-1:0] bw_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r <= BW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bw_r <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------
  // Handshake and raster counters
  // ---------------------------------------------------------------------
  logic             in_accept;
  logic             s1_valid_r;
  logic             s1_produce;
  logic             s1_adv;
  logic             out_valid_r;
  logic [IDX_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] col_r, col_nxt;
  logic [IDX_W-1:0] acc_row;
  logic [IDX_W-1:0] acc_col;

  // The stage word moves on unless it has a result and the output register
  // is full and stalled.
  assign s1_adv    = s1_valid_r && (!s1_produce || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // Start of frame overrides the running position before the pixel is used.
  assign acc_row = in_start_of_frame ? '0 : row_r;
  assign acc_col = in_start_of_frame ? '0 : col_r;

  always_comb begin
    row_nxt = acc_row;
    col_nxt = acc_col + IDX_W'(1);
    if (acc_col == LAST_IDX) begin
      col_nxt = '0;
      row_nxt = (acc_row == LAST_IDX) ? '0 : acc_row + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_accept) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage register: the accepted pixel while its line-store read completes
  // ---------------------------------------------------------------------
  logic signed [GRAD_BITS-1:0] s1_gx_r;
  logic signed [GRAD_BITS-1:0] s1_gy_r;
  logic [MAG_BITS-1:0]         s1_mag_r;
  logic [IDX_W-1:0]            s1_row_r;
  logic [IDX_W-1:0]            s1_col_r;
  logic                        fwd_r, fwd_nxt;
  logic [LINE_W-1:0]           fwd_data_r;
  logic [LINE_W-1:0]           line_wdata;
  logic [LINE_W-1:0]           line_rdata;

  // When the pixel just accepted reads the column the stage word writes at
  // the same edge, the RAM returns the stale entry; the write data is kept
  // and used in its place.
  assign fwd_nxt = s1_adv && (s1_col_r == acc_col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_gx_r    <= in_grad_x;
      s1_gy_r    <= in_grad_y;
      s1_mag_r   <= in_magnitude;
      s1_row_r   <= acc_row;
      s1_col_r   <= acc_col;
      fwd_r      <= fwd_nxt;
      fwd_data_r <= line_wdata;
    end
  end

  cnms_ram #(
    .WIDTH (LINE_W),
    .DEPTH (IMAGE_SIZE)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (line_wdata),
    .re    (in_accept),
    .raddr (acc_col),
    .rdata (line_rdata)
  );

  // ---------------------------------------------------------------------
  // Stage logic: window column, line-store update, sector, suppression
  // ---------------------------------------------------------------------
  logic [LINE_W-1:0]   line_eff;
  logic [MAG_BITS-1:0] col_up;
  logic [MAG_BITS-1:0] col_mid;
  sector_t             line_sec;
  sector_t             pix_sec;

  assign line_eff = fwd_r ? fwd_data_r : line_rdata;
  assign col_mid  = line_eff[LINE_W-1 -: MAG_BITS];
  assign col_up   = line_eff[SEC_W +: MAG_BITS];
  assign line_sec = sector_t'(line_eff[SEC_W-1:0]);

  // The sector is worked out once when the pixel enters the line store and
  // read back when that pixel becomes the centre, a line and a pixel later.
  cnms_sector #(
    .GRAD_BITS (GRAD_BITS)
  ) u_sector (
    .grad_x (s1_gx_r),
    .grad_y (s1_gy_r),
    .sector (pix_sec)
  );

  // The middle line moves up, the new pixel becomes the middle line.
  assign line_wdata = {s1_mag_r, col_mid, pix_sec};

  // Window: two older columns held here, the newest column comes from the
  // line store and the stage register. Index 0 is the top row.
  logic [MAG_BITS-1:0] win0_r [3];
  logic [MAG_BITS-1:0] win1_r [3];
  logic [MAG_BITS-1:0] new_col [3];
  sector_t             csec_r;

  assign new_col[0] = col_up;
  assign new_col[1] = col_mid;
  assign new_col[2] = s1_mag_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int i = 0; i < 3; i++) begin
        win0_r[i] <= win1_r[i];
        win1_r[i] <= new_col[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csec_r <= SEC_HORIZ;
    end else if (s1_adv) begin
      csec_r <= line_sec;
    end
  end

  // Centre position and border test.
  logic [IDX_W-1:0] ctr_row;
  logic [IDX_W-1:0] ctr_col;
  logic [BW_W-1:0]  bw_eff;
  logic             ctr_interior;
  logic [MAG_BITS-1:0] ctr_mag;
  logic [MAG_BITS-1:0] nb_a;
  logic [MAG_BITS-1:0] nb_b;
  logic             is_max;

  assign s1_produce = (s1_row_r != '0) && (s1_col_r != '0);
  assign ctr_row    = s1_row_r - IDX_W'(1);
  assign ctr_col    = s1_col_r - IDX_W'(1);
  // A zero border still keeps the outermost pixels from being edges.
  assign bw_eff     = (bw_r == '0) ? BW_W'(1) : bw_r;

  assign ctr_interior = (SUM_W'(ctr_row) >= SUM_W'(bw_eff)) &&
                        (SUM_W'(ctr_row) + SUM_W'(bw_eff) < SIZE_SUM) &&
                        (SUM_W'(ctr_col) >= SUM_W'(bw_eff)) &&
                        (SUM_W'(ctr_col) + SUM_W'(bw_eff) < SIZE_SUM);

  assign ctr_mag = win1_r[1];

  // Pick the two neighbours along the centre's gradient direction.
  always_comb begin
    case (csec_r)
      SEC_HORIZ: begin
        nb_a = win0_r[1];
        nb_b = new_col[1];
      end
      SEC_RISING: begin
        nb_a = win0_r[0];
        nb_b = new_col[2];
      end
      SEC_FALLING: begin
        nb_a = win0_r[2];
        nb_b = new_col[0];
      end
      default: begin
        nb_a = win1_r[0];
        nb_b = win1_r[2];
      end
    endcase
  end

  assign is_max = (ctr_mag > nb_a) && (ctr_mag > nb_b);

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic                 out_load;
  logic                 out_edge_r;
  sector_t              out_sec_r;
  logic [MAG_BITS-1:0]  out_mag_r;
  logic [IDX_OUT_W-1:0] out_row_r;
  logic [IDX_OUT_W-1:0] out_col_r;

  assign out_load = s1_adv && s1_produce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_edge_r <= ctr_interior && is_max;
      out_sec_r  <= csec_r;
      out_mag_r  <= ctr_mag;
      out_row_r  <= IDX_OUT_W'(ctr_row);
      out_col_r  <= IDX_OUT_W'(ctr_col);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_edge_flag        = out_edge_r;
  assign out_sector           = out_sec_r;
  assign out_center_magnitude = out_mag_r;
  assign out_row_index        = out_row_r;
  assign out_column_index     = out_col_r;

endmodule

### rtl/core/cnms_checker.sv
// ----------------------------------------------------------------------------
// Canny non-maximum suppression port checker
// Watches the unit's ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module cnms_checker #(
  parameter int MAG_BITS = cnms_pkg::MAG_BITS_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_edge_flag,
  input logic [1:0]                     out_sector,
  input logic [MAG_BITS-1:0]            out_center_magnitude,
  input logic [cnms_pkg::IDX_OUT_W-1:0] out_row_index,
  input logic [cnms_pkg::IDX_OUT_W-1:0] out_column_index
);

  // A stalled result word stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_edge_flag) &&
      $stable(out_sector) && $stable(out_center_magnitude) &&
      $stable(out_row_index) && $stable(out_column_index))
    else $error("result word changed while stalled");

  // The input only backs up behind a full, stalled output register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the output could move");

  // A local maximum is strictly above a neighbour, so it cannot be zero.
  a_edge_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_edge_flag |-> out_center_magnitude != '0)
    else $error("edge flagged on a zero magnitude");

endmodule

bind canny_non_max_suppression_unit cnms_checker #(
  .MAG_BITS (MAG_BITS)
) u_cnms_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_edge_flag        (out_edge_flag),
  .out_sector           (out_sector),
  .out_center_magnitude (out_center_magnitude),
  .out_row_index        (out_row_index),
  .out_column_index     (out_column_index)
);

### sim/canny_non_max_suppression_unit_tb.sv
// ----------------------------------------------------------------------------
// Canny non-maximum suppression unit testbench
// Streams gradient pixels through the unit in raster order and checks every
// result word against a cycle-free model of the line stores, the 3x3 window,
// the sector choice and the border rule. The run covers directed sector
// boundaries, a frame restarted in the middle of a row, interior rows with
// their left and right borders, and border widths of zero, one, the reset
// value and the top of the register, with random idling on both sides and
// long output hold-offs that back the unit up.
// ----------------------------------------------------------------------------
module canny_non_max_suppression_unit_tb;
  import cnms_pkg::*;

  localparam int IMAGE_SIZE = 256;
  localparam int MAG_BITS   = 16;
  localparam int GRAD_BITS  = 16;

  // Slope limits 0.4142 and 2.4142 over a common scale, kept apart from the
  // unit's own constants so that a wrong constant there shows up here.
  localparam longint SLOPE_SCALE = 10000;
  localparam longint SLOPE_LOW   = 4142;
  localparam longint SLOPE_HIGH  = 24142;
  localparam logic [BW_W-1:0] BORDER_AFTER_RESET = 6'd3;

  localparam int SETTLE_CYCLES  = 6;     // drain margin after the last result
  localparam int LONG_HOLD      = 400;   // output hold-off that fills the unit
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no word accepted
  localparam int CORNER_COUNT   = 24;

  typedef struct {
    logic signed [GRAD_BITS-1:0] gx;
    logic signed [GRAD_BITS-1:0] gy;
    logic [MAG_BITS-1:0]         mag;
    logic                        sof;
  } pixel_t;

  typedef struct {
    logic                 is_edge;
    sector_t              sec;
    logic [MAG_BITS-1:0]  mag;
    logic [IDX_OUT_W-1:0] row;
    logic [IDX_OUT_W-1:0] col;
  } nms_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                        in_valid          = 1'b0;
  logic                        in_stall;
  logic signed [GRAD_BITS-1:0] in_grad_x         = '0;
  logic signed [GRAD_BITS-1:0] in_grad_y         = '0;
  logic [MAG_BITS-1:0]         in_magnitude      = '0;
  logic                        in_start_of_frame = 1'b0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_edge_flag;
  logic [1:0]           out_sector;
  logic [MAG_BITS-1:0]  out_center_magnitude;
  logic [IDX_OUT_W-1:0] out_row_index;
  logic [IDX_OUT_W-1:0] out_column_index;

  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [BW_W-1:0] cfg_data  = '0;

  canny_non_max_suppression_unit #(
    .IMAGE_SIZE(IMAGE_SIZE),
    .MAG_BITS  (MAG_BITS),
    .GRAD_BITS (GRAD_BITS)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_grad_x           (in_grad_x),
    .in_grad_y           (in_grad_y),
    .in_magnitude        (in_magnitude),
    .in_start_of_frame   (in_start_of_frame),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_edge_flag       (out_edge_flag),
    .out_sector          (out_sector),
    .out_center_magnitude(out_center_magnitude),
    .out_row_index       (out_row_index),
    .out_column_index    (out_column_index),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data)
  );

  // Pixels waiting to be offered, and results still owed by the unit.
  pixel_t      pending_pixels[$];
  nms_result_t awaited_results[$];

  int unsigned pixels_queued   = 0;
  int unsigned pixels_taken    = 0;
  int unsigned results_checked = 0;
  int unsigned edges_seen      = 0;
  int unsigned sector_seen[4]  = '{0, 0, 0, 0};
  int unsigned mismatches      = 0;
  int unsigned borders_written = 0;
  int unsigned idle_cycles     = 0;

  // Shadow copy of the unit's state; all but the border width start cleared.
  logic [MAG_BITS-1:0]         upper_line [IMAGE_SIZE];
  logic [MAG_BITS-1:0]         middle_line[IMAGE_SIZE];
  logic signed [GRAD_BITS-1:0] line_gx    [IMAGE_SIZE];
  logic signed [GRAD_BITS-1:0] line_gy    [IMAGE_SIZE];
  logic [MAG_BITS-1:0]         win[3][3];  // [row][column], column 2 newest
  logic signed [GRAD_BITS-1:0] centre_gx;
  logic signed [GRAD_BITS-1:0] centre_gy;
  int unsigned                 row_cnt;
  int unsigned                 col_cnt;
  logic [BW_W-1:0]             border_w;

  initial begin
    forever #5 clk = ~clk;
  end

  // Sector of a gradient. A zero x gradient counts as a tiny positive one,
  // so only whether y is zero matters then: zero gives horizontal, any other vertical.
  function automatic sector_t classify_direction(input logic signed [GRAD_BITS-1:0] gx_in,
                                                 input logic signed [GRAD_BITS-1:0] gy_in);
    longint gx;
    longint gy;
    longint g;
    longint lo;
    longint hi;
    gx = gx_in;
    gy = gy_in;
    if (gx == 0) begin
      return (gy == 0) ? SEC_HORIZ : SEC_VERT;
    end
    if (gx < 0) begin
      gx = -gx;
      gy = -gy;
    end
    g  = gy * SLOPE_SCALE;
    lo = gx * SLOPE_LOW;
    hi = gx * SLOPE_HIGH;
    if (g <= lo && g > -lo) return SEC_HORIZ;
    if (g <= hi && g > lo) return SEC_RISING;
    if (g <= -lo && g > -hi) return SEC_FALLING;
    return SEC_VERT;
  endfunction

  // Advances the shadow state by one pixel. Returns 1 with the result word
  // when the pixel completes the window of a centre one row up, one left.
  function automatic bit step_pixel(input pixel_t px, output nms_result_t res);
    int unsigned r;
    int unsigned c;
    int unsigned ci;
    int unsigned cj;
    int unsigned bw;
    logic [MAG_BITS-1:0] up;
    logic [MAG_BITS-1:0] mid;
    logic [MAG_BITS-1:0] centre;
    logic signed [GRAD_BITS-1:0] cgx;
    logic signed [GRAD_BITS-1:0] cgy;
    sector_t sec;
    bit interior;
    bit flag;
    bit made;
    made = 1'b0;
    if (px.sof) begin
      row_cnt = 0;
      col_cnt = 0;
    end
    r = row_cnt;
    c = col_cnt;

    up  = upper_line[c];
    mid = middle_line[c];
    upper_line[c]  = mid;
    middle_line[c] = px.mag;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = px.mag;

    cgx = centre_gx;
    cgy = centre_gy;
    centre_gx  = line_gx[c];
    centre_gy  = line_gy[c];
    line_gx[c] = px.gx;
    line_gy[c] = px.gy;

    if (r >= 1 && c >= 1) begin
      ci = r - 1;
      cj = c - 1;
      // A zero border still keeps the outermost ring out of the edge map.
      bw = (border_w == '0) ? 1 : 32'(border_w);
      interior = ci >= bw && ci + bw < IMAGE_SIZE && cj >= bw && cj + bw < IMAGE_SIZE;
      sec    = classify_direction(cgx, cgy);
      centre = win[1][1];
      flag   = 1'b0;
      if (interior) begin
        case (sec)
          SEC_HORIZ:   flag = centre > win[1][0] && centre > win[1][2];
          SEC_RISING:  flag = centre > win[0][0] && centre > win[2][2];
          SEC_FALLING: flag = centre > win[2][0] && centre > win[0][2];
          default:     flag = centre > win[0][1] && centre > win[2][1];
        endcase
      end
      res.is_edge = flag;
      res.sec     = sec;
      res.mag     = centre;
      res.row     = ci[IDX_OUT_W-1:0];
      res.col     = cj[IDX_OUT_W-1:0];
      made = 1'b1;
    end

    c++;
    if (c >= IMAGE_SIZE) begin
      c = 0;
      r++;
      if (r >= IMAGE_SIZE) r = 0;
    end
    row_cnt = r;
    col_cnt = c;
    return made;
  endfunction

  // Gradients that sit on or next to the sector limits, at the extremes of
  // the field, or with a zero x component.
  function automatic logic [2*GRAD_BITS-1:0] corner_gradient(input int unsigned k);
    case (k)
      0:       return {16'sd0, 16'sd0};
      1:       return {16'sd0, 16'sd5};
      2:       return {16'sd0, 16'h8000};
      3:       return {16'h7FFF, 16'sd0};
      4:       return {16'h8000, 16'sd0};
      5:       return {16'sd5000, 16'sd2071};
      6:       return {16'sd5000, 16'sd2072};
      7:       return {16'sd5000, 16'sd12071};
      8:       return {16'sd5000, 16'sd12072};
      9:       return {16'sd5000, -16'sd2071};
      10:      return {16'sd5000, -16'sd2070};
      11:      return {16'sd5000, -16'sd12071};
      12:      return {16'sd5000, -16'sd12070};
      13:      return {-16'sd5000, 16'sd2071};
      14:      return {-16'sd5000, -16'sd2071};
      15:      return {16'h8000, 16'h8000};
      16:      return {16'h7FFF, 16'h8000};
      17:      return {16'sd1, 16'h7FFF};
      18:      return {16'h7FFF, 16'sd1};
      19:      return {-16'sd1, 16'sd0};
      20:      return {-16'sd1, 16'sd1};
      21:      return {16'sd1, -16'sd3};
      22:      return {16'sd2, 16'sd1};
      default: return {16'h8000, 16'h7FFF};
    endcase
  endfunction

  function automatic pixel_t random_pixel(input bit sof);
    pixel_t px;
    logic [2*GRAD_BITS-1:0] pair;
    int k;
    case ($urandom_range(9, 0))
      0, 1, 2, 3: begin
        px.gx = GRAD_BITS'($urandom);
        px.gy = GRAD_BITS'($urandom);
      end
      4, 5: begin
        px.gx = GRAD_BITS'(int'($urandom_range(80, 0)) - 40);
        px.gy = GRAD_BITS'(int'($urandom_range(80, 0)) - 40);
      end
      6: begin
        pair  = corner_gradient($urandom_range(CORNER_COUNT - 1, 0));
        px.gx = pair[2*GRAD_BITS-1:GRAD_BITS];
        px.gy = pair[GRAD_BITS-1:0];
      end
      7: begin
        px.gx = '0;
        px.gy = $urandom_range(1, 0) ? '0 : GRAD_BITS'($urandom);
      end
      default: begin
        // On a tangent limit or one step either side of it, in any quadrant.
        k     = $urandom_range(2, 1);
        px.gx = GRAD_BITS'(5000 * k);
        px.gy = GRAD_BITS'(($urandom_range(1, 0) ? 12071 : 2071) * k +
                           int'($urandom_range(2, 0)) - 1);
        case ($urandom_range(3, 0))
          1: px.gy = -px.gy;
          2: px.gx = -px.gx;
          3: begin
            px.gx = -px.gx;
            px.gy = -px.gy;
          end
          default: ;
        endcase
      end
    endcase
    case ($urandom_range(7, 0))
      5:       px.mag = MAG_BITS'($urandom_range(3, 0));         // ties are common
      6:       px.mag = $urandom_range(1, 0) ? '1 : '0;
      7:       px.mag = MAG_BITS'(1000 + $urandom_range(1, 0));  // flat plateau
      default: px.mag = MAG_BITS'($urandom);
    endcase
    px.sof = sof;
    return px;
  endfunction

  task automatic queue_pixels(input int count, input bit sof_first);
    for (int i = 0; i < count; i++) begin
      pending_pixels.push_back(random_pixel(sof_first && i == 0));
      pixels_queued++;
    end
  endtask

  // Waits until every queued pixel has been taken and every result has come
  // back, then lets the pipeline run dry of pixels that owe no result.
  task automatic wait_idle();
    do @(posedge clk);
    while (pixels_taken != pixels_queued || awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_border(input logic [BW_W-1:0] width);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= width;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    border_w = width;
    borders_written++;
  endtask

  task automatic check_field(input string field, input int unsigned wanted,
                             input int unsigned got, input nms_result_t exp_r);
    if (wanted != got) begin
      mismatches++;
      $display("%0t: %s of centre (%0d,%0d) expected %0d, actual %0d",
               $time, field, exp_r.row, exp_r.col, wanted, got);
    end
  endtask

  // Pixel driver. Each word may be followed by an idle gap, except in every
  // third stretch of 400 words, which is sent back to back.
  int unsigned words_sent = 0;
  int unsigned send_wait  = 0;

  always @(posedge clk) begin
    pixel_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        words_sent++;
        send_wait = $urandom_range(((words_sent / 400) % 3 == 2) ? 0 : 7, 0);
      end
      if (send_wait == 0 && pending_pixels.size() != 0) begin
        nxt = pending_pixels.pop_front();
        in_valid          <= 1'b1;
        in_grad_x         <= nxt.gx;
        in_grad_y         <= nxt.gy;
        in_magnitude      <= nxt.mag;
        in_start_of_frame <= nxt.sof;
      end else begin
        if (send_wait != 0) send_wait--;
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink. After each word it may stall, but not in every third stretch
  // of 300 words, and twice it stalls for a long hold-off while the driver
  // keeps offering pixels, so that the unit fills and stalls its input.
  int unsigned words_drained = 0;
  int unsigned sink_wait     = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      sink_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        words_drained++;
        if (words_drained == 300 || words_drained == 1100) begin
          sink_wait = LONG_HOLD;
        end else begin
          sink_wait = $urandom_range(((words_drained / 300) % 3 == 1) ? 0 : 7, 0);
        end
      end
      if (sink_wait != 0) begin
        out_stall <= 1'b1;
        sink_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: predicts on every accepted pixel, then checks every accepted
  // result against the oldest prediction.
  always @(posedge clk) begin
    pixel_t      px;
    nms_result_t exp_r;
    nms_result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        px.gx  = in_grad_x;
        px.gy  = in_grad_y;
        px.mag = in_magnitude;
        px.sof = in_start_of_frame;
        if (step_pixel(px, exp_r)) awaited_results.push_back(exp_r);
        pixels_taken++;
      end
      if (out_valid && !out_stall) begin
        got.is_edge = out_edge_flag;
        got.sec     = sector_t'(out_sector);
        got.mag     = out_center_magnitude;
        got.row     = out_row_index;
        got.col     = out_column_index;
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, expected nothing, actual centre (%0d,%0d)",
                   $time, got.row, got.col);
        end else begin
          exp_r = awaited_results.pop_front();
          check_field("edge flag", exp_r.is_edge, got.is_edge, exp_r);
          check_field("sector", exp_r.sec, got.sec, exp_r);
          check_field("centre magnitude", exp_r.mag, got.mag, exp_r);
          check_field("row index", exp_r.row, got.row, exp_r);
          check_field("column index", exp_r.col, got.col, exp_r);
          results_checked++;
          edges_seen += exp_r.is_edge;
          sector_seen[exp_r.sec]++;
        end
      end
    end
  end

  // Watchdog on progress: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    pixel_t px;
    logic [2*GRAD_BITS-1:0] pair;
    for (int i = 0; i < IMAGE_SIZE; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
      line_gx[i]     = '0;
      line_gy[i]     = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    end
    centre_gx = '0;
    centre_gy = '0;
    row_cnt   = 0;
    col_cnt   = 0;
    border_w  = BORDER_AFTER_RESET;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening of the first frame: the corner gradients fill row 0
    // and are reported as border centres once row 1 streams past. The first
    // one also carries a start-of-frame mark at a point already at row 0.
    for (int k = 0; k < CORNER_COUNT; k++) begin
      pair   = corner_gradient(k);
      px.gx  = pair[2*GRAD_BITS-1:GRAD_BITS];
      px.gy  = pair[GRAD_BITS-1:0];
      px.mag = (k % 3 == 0) ? '1 : (k % 3 == 1) ? '0 : MAG_BITS'(k);
      px.sof = (k == 0);
      pending_pixels.push_back(px);
      pixels_queued++;
    end
    // The rest of five rows under the border width left by reset, so that the
    // fourth row of centres has an interior with borders on both sides, and a
    // few pixels past the column wrap.
    queue_pixels(5 * IMAGE_SIZE + 4 - CORNER_COUNT, 1'b0);
    wait_idle();

    // A zero border behaves as one. The frame restarts in the middle of a row
    // and its third input row gives interior centres.
    set_border(6'd0);
    queue_pixels(2 * IMAGE_SIZE + 40, 1'b1);
    wait_idle();

    // The top of the register keeps every centre in the border; the frame
    // goes on with no new mark.
    set_border(6'd63);
    queue_pixels(24, 1'b0);
    wait_idle();

    // Narrowest border on the same row.
    set_border(6'd1);
    queue_pixels(24, 1'b0);
    wait_idle();

    $display("Run covered %0d pixels and %0d result words, %0d of them edges, under %0d border writes.",
             pixels_taken, results_checked, edges_seen, borders_written);
    $display("Sectors checked: horizontal %0d, rising %0d, falling %0d, vertical %0d; %0d mismatches.",
             sector_seen[0], sector_seen[1], sector_seen[2], sector_seen[3], mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
